// ----- rtl/xdg_pkg.sv -----
// ----------------------------------------------------------------------------
// xdg_pkg: shared types and constants of the X-drop gapped alignment scorer
// Command codes, the classified job handed from front to back, and score widths.
// ----------------------------------------------------------------------------
package xdg_pkg;

    localparam int MAX_LEN       = 256;
    localparam int ALPHABET_SIZE = 16;
    localparam int LEN_W         = 9;
    localparam int LET_W         = 4;
    localparam int SCORE_W       = 32;
    localparam int WIDE_W        = 34;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_score NEG_HALF = -t_score'(1073741824);

    typedef enum logic [1:0] {
        CMD_TABLE  = 2'd0,
        CMD_LOAD_A = 2'd1,
        CMD_LOAD_B = 2'd2,
        CMD_RUN    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_OPEN   = 2'd0,
        CFG_GAP_EXTEND = 2'd1,
        CFG_DROP_LIMIT = 2'd2,
        CFG_REVERSE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        JOB_NONE  = 3'd0,
        JOB_TABLE = 3'd1,
        JOB_A     = 3'd2,
        JOB_B     = 3'd3,
        JOB_RUN   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [3:0]               tab_row;
        logic [3:0]               tab_col;
        logic signed [7:0]        tab_score;
        logic [LEN_W-1:0]         pos;
        logic [LET_W-1:0]         letter;
        logic [LEN_W-1:0]         len_a;
        logic [LEN_W-1:0]         len_b;
    } t_job;

endpackage

// ----- rtl/xdg_in_if.sv -----
// ----------------------------------------------------------------------------
// xdg_in_if: request channel of the X-drop scorer
// Valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface xdg_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [3:0]        table_row;
    logic [3:0]        table_col;
    logic signed [7:0] table_score;
    logic [8:0]        position;
    logic [3:0]        letter;
    logic [8:0]        length_a;
    logic [8:0]        length_b;

    modport source (
        output valid, cmd, table_row, table_col, table_score, position, letter,
               length_a, length_b,
        input  ready
    );
    modport sink (
        input  valid, cmd, table_row, table_col, table_score, position, letter,
               length_a, length_b,
        output ready
    );
endinterface

// ----- rtl/xdg_out_if.sv -----
// ----------------------------------------------------------------------------
// xdg_out_if: result channel of the X-drop scorer
// Valid/ready handshake with best score and its end cell.
// ----------------------------------------------------------------------------
interface xdg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] top_score;
    logic [8:0]  a_end;
    logic [8:0]  b_end;

    modport source (
        output valid, top_score, a_end, b_end,
        input  ready
    );
    modport sink (
        input  valid, top_score, a_end, b_end,
        output ready
    );
endinterface

// ----- rtl/xdg_ram.sv -----
// ----------------------------------------------------------------------------
// xdg_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module xdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/xdg_front.sv -----
// ----------------------------------------------------------------------------
// xdg_front: request intake and classification
// Decodes each request into a job, drops out-of-range writes, saturates run
// lengths, and holds jobs in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module xdg_front
    import xdg_pkg::*;
#(
    parameter int ALPHA_SIZE = ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xdg_in_if.sink     i_in,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_ready
);
    t_job       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_job       new_job;
    logic       tab_ok;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];
    assign pop         = o_job_valid && i_job_ready;

    assign tab_ok = (32'(i_in.table_row) < ALPHA_SIZE) && (32'(i_in.table_col) < ALPHA_SIZE);

    always_comb begin
        new_job           = '0;
        new_job.tab_row   = i_in.table_row;
        new_job.tab_col   = i_in.table_col;
        new_job.tab_score = i_in.table_score;
        new_job.pos       = i_in.position;
        new_job.letter    = i_in.letter;
        new_job.len_a     = (32'(i_in.length_a) > MAX_LEN) ? LEN_W'(MAX_LEN) : i_in.length_a;
        new_job.len_b     = (32'(i_in.length_b) > MAX_LEN) ? LEN_W'(MAX_LEN) : i_in.length_b;
        case (t_cmd'(i_in.cmd))
            CMD_TABLE:  new_job.kind = tab_ok ? JOB_TABLE : JOB_NONE;
            CMD_LOAD_A: new_job.kind = (32'(i_in.position) <= MAX_LEN) ? JOB_A : JOB_NONE;
            CMD_LOAD_B: new_job.kind = (32'(i_in.position) <= MAX_LEN) ? JOB_B : JOB_NONE;
            CMD_RUN:    new_job.kind = JOB_RUN;
            default:    new_job.kind = JOB_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= new_job;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- rtl/xdg_back.sv -----
// ----------------------------------------------------------------------------
// xdg_back: alignment engine
// Performs store writes and walks the banded affine-gap DP one column at a
// time over the row memories, then presents the result in an output register.
// ----------------------------------------------------------------------------
module xdg_back
    import xdg_pkg::*;
#(
    parameter int ALPHA_SIZE = ALPHABET_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_ready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    xdg_out_if.source             o_res
);
    localparam int TDEPTH = ALPHA_SIZE * ALPHA_SIZE;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int SDEPTH = MAX_LEN + 1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_INIT     = 10'b0000000010,
        S_ROW_RD   = 10'b0000000100,
        S_COL_RD   = 10'b0000001000,
        S_COL_TBL  = 10'b0000010000,
        S_COL_CALC = 10'b0000100000,
        S_ROW_END  = 10'b0001000000,
        S_EXT      = 10'b0010000000,
        S_CAP      = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state r_st, n_st;

    logic [7:0]  r_gap_open, r_gap_ext;
    logic [15:0] r_drop;
    logic        r_rev_cfg, r_rev, n_rev;

    logic [LEN_W-1:0] r_m, n_m, r_n, n_n, r_a, n_a, r_b, n_b, r_i, n_i;
    logic [LEN_W-1:0] r_first, n_first, r_last, n_last, r_size, n_size;
    logic [LEN_W-1:0] r_a_end, n_a_end, r_b_end, n_b_end;
    t_score r_goe, n_goe, r_ext, n_ext, r_xd, n_xd;
    t_score r_score, n_score, r_gap_row, n_gap_row, r_best, n_best;
    t_score r_sc, n_sc, r_rb, n_rb, r_gc, n_gc;
    logic   r_sub_ok, n_sub_ok;

    logic        r_out_valid;
    logic [15:0] r_out_best;
    logic [8:0]  r_out_a, r_out_b;

    // memory ports
    logic               tbl_we, sa_we, sb_we, rb_we, rg_we;
    logic [TAW-1:0]     tbl_waddr, tbl_raddr;
    logic [7:0]         tbl_rdata;
    logic [LEN_W-1:0]   sa_raddr, sb_raddr, row_waddr;
    logic [LET_W-1:0]   sa_rdata, sb_rdata, lb;
    t_score             rb_wdata, rg_wdata, rb_rdata, rg_rdata;

    logic   pop, out_load;
    t_score goe_c, xd_c, sub, sc_pre, nxt, gc_dec, sc_goe, gr_dec;
    t_wide  drop_diff;
    logic   prune;

    assign o_job_ready = (r_st == S_IDLE);
    assign pop         = i_job_valid && o_job_ready;

    // store writes from load jobs
    assign tbl_we    = pop && (i_job.kind == JOB_TABLE);
    assign sa_we     = pop && (i_job.kind == JOB_A);
    assign sb_we     = pop && (i_job.kind == JOB_B);
    assign tbl_waddr = TAW'(32'(i_job.tab_row) * ALPHA_SIZE + 32'(i_job.tab_col));

    // sequence reads follow the current row and column
    assign sa_raddr = r_rev ? (r_m - r_a) : r_a;
    assign sb_raddr = (r_b < r_n) ? (r_rev ? (r_n - r_b - LEN_W'(1)) : (r_b + LEN_W'(1)))
                                  : '0;
    assign lb        = (r_b < r_n) ? sb_rdata : '0;
    assign tbl_raddr = TAW'(32'(sa_rdata) * ALPHA_SIZE + 32'(lb));

    xdg_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_table (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(tbl_waddr), .i_wdata(i_job.tab_score),
        .i_raddr(tbl_raddr), .o_rdata(tbl_rdata)
    );
    xdg_ram #(.WIDTH(LET_W), .DEPTH(SDEPTH)) u_seq_a (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(i_job.pos), .i_wdata(i_job.letter),
        .i_raddr(sa_raddr), .o_rdata(sa_rdata)
    );
    xdg_ram #(.WIDTH(LET_W), .DEPTH(SDEPTH)) u_seq_b (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(i_job.pos), .i_wdata(i_job.letter),
        .i_raddr(sb_raddr), .o_rdata(sb_rdata)
    );
    xdg_ram #(.WIDTH(SCORE_W), .DEPTH(SDEPTH)) u_row_best (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(row_waddr), .i_wdata(rb_wdata),
        .i_raddr(r_b), .o_rdata(rb_rdata)
    );
    xdg_ram #(.WIDTH(SCORE_W), .DEPTH(SDEPTH)) u_row_gap (
        .i_clk(i_clk), .i_we(rg_we), .i_waddr(row_waddr), .i_wdata(rg_wdata),
        .i_raddr(r_b), .o_rdata(rg_rdata)
    );

    assign goe_c = t_score'(r_gap_open) + t_score'(r_gap_ext);
    assign xd_c  = (t_score'(r_drop) < goe_c) ? goe_c : t_score'(r_drop);

    // column arithmetic
    always_comb begin
        sc_pre = r_score;
        if (sc_pre < rg_rdata) begin
            sc_pre = rg_rdata;
        end
        if (sc_pre < r_gap_row) begin
            sc_pre = r_gap_row;
        end
    end
    assign sub       = r_sub_ok ? t_score'(signed'(tbl_rdata)) : '0;
    assign nxt       = r_rb + sub;
    assign drop_diff = t_wide'(r_best) - t_wide'(r_sc);
    assign prune     = drop_diff > t_wide'(r_xd);
    assign sc_goe    = r_sc - r_goe;
    assign gc_dec    = r_gc - r_ext;
    assign gr_dec    = r_gap_row - r_ext;
    assign out_load  = (r_st == S_DONE) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_st = r_st;
        n_rev = r_rev; n_m = r_m; n_n = r_n; n_a = r_a; n_b = r_b; n_i = r_i;
        n_first = r_first; n_last = r_last; n_size = r_size;
        n_a_end = r_a_end; n_b_end = r_b_end;
        n_goe = r_goe; n_ext = r_ext; n_xd = r_xd;
        n_score = r_score; n_gap_row = r_gap_row; n_best = r_best;
        n_sc = r_sc; n_rb = r_rb; n_gc = r_gc; n_sub_ok = r_sub_ok;
        rb_we = 1'b0; rg_we = 1'b0; row_waddr = r_b; rb_wdata = r_sc; rg_wdata = r_sc;

        case (r_st)
            S_IDLE: begin
                if (pop && (i_job.kind == JOB_RUN)) begin
                    n_rev   = r_rev_cfg;
                    n_m     = i_job.len_a;
                    n_n     = i_job.len_b;
                    n_goe   = goe_c;
                    n_ext   = t_score'(r_gap_ext);
                    n_xd    = xd_c;
                    n_best  = '0;
                    n_a_end = '0;
                    n_b_end = '0;
                    n_i     = '0;
                    n_first = '0;
                    n_size  = '0;
                    n_score = -goe_c;
                    if ((i_job.len_a == '0) || (i_job.len_b == '0)) begin
                        n_st = S_DONE;
                    end else begin
                        n_st = S_INIT;
                    end
                end
            end
            S_INIT: begin
                row_waddr = r_i;
                if (r_i == '0) begin
                    rb_we = 1'b1; rb_wdata = '0;
                    rg_we = 1'b1; rg_wdata = -r_goe;
                    n_i   = LEN_W'(1);
                end else if ((r_i <= r_n) && !(r_score < -r_xd)) begin
                    rb_we = 1'b1; rb_wdata = r_score;
                    rg_we = 1'b1; rg_wdata = r_score - r_goe;
                    n_score = r_score - r_ext;
                    n_i     = r_i + LEN_W'(1);
                end else begin
                    n_size    = r_i;
                    n_a       = LEN_W'(1);
                    n_b       = r_first;
                    n_last    = r_first;
                    n_score   = NEG_HALF;
                    n_gap_row = NEG_HALF;
                    n_st      = S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                n_st = S_COL_RD;
            end
            S_COL_RD: begin
                n_st = S_COL_TBL;
            end
            S_COL_TBL: begin
                n_sc     = sc_pre;
                n_rb     = rb_rdata;
                n_gc     = rg_rdata;
                n_sub_ok = (32'(sa_rdata) < ALPHA_SIZE) && (32'(lb) < ALPHA_SIZE);
                n_st     = S_COL_CALC;
            end
            S_COL_CALC: begin
                row_waddr = r_b;
                if (prune) begin
                    if (r_first == r_b) begin
                        n_first = r_first + LEN_W'(1);
                    end else begin
                        rb_we = 1'b1; rb_wdata = NEG_HALF;
                    end
                end else begin
                    n_last = r_b;
                    if (r_sc > r_best) begin
                        n_best  = r_sc;
                        n_a_end = r_a;
                        n_b_end = r_b;
                    end
                    rg_we     = 1'b1;
                    rg_wdata  = (gc_dec < sc_goe) ? sc_goe : gc_dec;
                    n_gap_row = (gr_dec < sc_goe) ? sc_goe : gr_dec;
                    rb_we     = 1'b1;
                    rb_wdata  = r_sc;
                end
                n_score = nxt;
                if ((r_b + LEN_W'(1)) < r_size) begin
                    n_b  = r_b + LEN_W'(1);
                    n_st = S_COL_RD;
                end else begin
                    n_st = S_ROW_END;
                end
            end
            S_ROW_END: begin
                if (r_first == r_size) begin
                    n_st = S_DONE;
                end else if ((r_last + LEN_W'(1)) < r_size) begin
                    n_size = r_last + LEN_W'(1);
                    n_st   = S_CAP;
                end else begin
                    n_st = S_EXT;
                end
            end
            S_EXT: begin
                // trailing horizontal gap widens the band to the right
                row_waddr = r_size;
                if ((r_gap_row >= (r_best - r_xd)) && (r_size <= r_n)) begin
                    rb_we = 1'b1; rb_wdata = r_gap_row;
                    rg_we = 1'b1; rg_wdata = r_gap_row - r_goe;
                    n_gap_row = gr_dec;
                    n_size    = r_size + LEN_W'(1);
                end else begin
                    n_st = S_CAP;
                end
            end
            S_CAP: begin
                row_waddr = r_size;
                if (r_size <= r_n) begin
                    rb_we = 1'b1; rb_wdata = NEG_HALF;
                    rg_we = 1'b1; rg_wdata = NEG_HALF;
                    n_size = r_size + LEN_W'(1);
                end
                if (r_a == r_m) begin
                    n_st = S_DONE;
                end else begin
                    n_a       = r_a + LEN_W'(1);
                    n_b       = r_first;
                    n_last    = r_first;
                    n_score   = NEG_HALF;
                    n_gap_row = NEG_HALF;
                    n_st      = S_ROW_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rev <= n_rev; r_m <= n_m; r_n <= n_n; r_a <= n_a; r_b <= n_b; r_i <= n_i;
        r_first <= n_first; r_last <= n_last; r_size <= n_size;
        r_a_end <= n_a_end; r_b_end <= n_b_end;
        r_goe <= n_goe; r_ext <= n_ext; r_xd <= n_xd;
        r_score <= n_score; r_gap_row <= n_gap_row; r_best <= n_best;
        r_sc <= n_sc; r_rb <= n_rb; r_gc <= n_gc; r_sub_ok <= n_sub_ok;
        if (out_load) begin
            r_out_best <= r_best[15:0];
            r_out_a    <= r_a_end;
            r_out_b    <= r_b_end;
        end
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gap_open  <= 8'd5;
            r_gap_ext   <= 8'd2;
            r_drop      <= 16'd16;
            r_rev_cfg   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAP_OPEN:   r_gap_open <= i_cfg_data[7:0];
                    CFG_GAP_EXTEND: r_gap_ext  <= i_cfg_data[7:0];
                    CFG_DROP_LIMIT: r_drop     <= i_cfg_data;
                    CFG_REVERSE:    r_rev_cfg  <= i_cfg_data[0];
                    default:        r_rev_cfg  <= r_rev_cfg;
                endcase
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.top_score = r_out_best;
    assign o_res.a_end     = r_out_a;
    assign o_res.b_end     = r_out_b;

    // The column being scored always lies inside the live band.
    a_col_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_COL_CALC) |-> ((r_b < r_size) && (r_first <= r_b)))
        else $error("column outside band");

    // The band never reaches past one column beyond the end of B.
    a_band_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == S_ROW_END) || (r_st == S_EXT) || (r_st == S_CAP))
            |-> (r_size <= (r_n + LEN_W'(1))))
        else $error("band size beyond sequence B");

    // A finished run is not overwritten while its result still waits.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out_best)))
        else $error("pending result lost");

    // The best score never falls below zero.
    a_best_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> (r_best >= 0))
        else $error("negative best score");
endmodule

// ----- rtl/xdrop_gapped_alignment_score_core.sv -----
// ----------------------------------------------------------------------------
// xdrop_gapped_alignment_score_core: affine-gap X-drop extension scorer
// Loads a substitution table and two letter stores, then scores a run.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: table writes, letter writes for A and B, and runs.
//   Each accepted run request yields one result on o_res (best score and its
//   end cell); load requests yield nothing. Configuration registers are written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   Load requests complete one per cycle after a two-entry request queue, while
//   the engine is idle. Each column step passes through S_COL_RD, S_COL_TBL
//   and S_COL_CALC, because each column waits on a row memory read and then a
//   substitution table read.
//   Runs with a zero length go straight from S_IDLE to S_DONE after they leave
//   the queue.
// Reset:
//   Synchronous, active low. Registers return to open 5, extend 2, drop 16,
//   forward mode. Table and letter stores keep whatever they hold.
// Stalls:
//   A result waits in the output register while o_res.ready is low; the engine
//   holds the next run at its end, while the queue accepts requests until both
//   of its entries are full.
// ----------------------------------------------------------------------------
module xdrop_gapped_alignment_score_core
    import xdg_pkg::*;
#(
    parameter int ALPHA_SIZE = ALPHABET_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    xdg_in_if.sink                i_in,
    xdg_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic job_valid, job_ready;
    t_job job;

    xdg_front #(.ALPHA_SIZE(ALPHA_SIZE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready)
    );

    xdg_back #(.ALPHA_SIZE(ALPHA_SIZE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_res(o_res)
    );
endmodule
